/* rtl/bpas_pkg.sv */
// Shared constants and elaboration-time functions for the Bezier point splat block.
`default_nettype none
package bpas_pkg;

   localparam int T_FRAC_BITS_DEF      = 16;
   localparam int COORD_BITS_DEF       = 10;
   localparam int WEIGHT_ROM_DEPTH_DEF = 256;

   // fraction bits of curve coordinates and of frac outputs
   localparam int PFRAC     = 16;
   localparam int EXP_TERMS = 24;

   // squared distance is Q.32 up to 2^33
   localparam int D2_BITS    = 2 * PFRAC + 2;
   localparam int D2_SHIFT   = 2 * PFRAC + 1;
   localparam int WEIGHT_BITS = 8;
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = 8'd255;

   localparam int CELL_LAT  = 3;
   localparam int LEVELS    = 3;
   localparam int SPLAT_LAT = 3;
   localparam int LATENCY   = 1 + LEVELS * CELL_LAT + SPLAT_LAT;

   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_P0_X = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_P0_Y = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_P1_X = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_P1_Y = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_P2_X = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_P2_Y = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_P3_X = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_P3_Y = 3'd7;

   function automatic logic [63:0] isqrt(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] c;
      r = 64'd0;
      for (int i = 20; i >= 0; i--) begin
         c = r | (64'd1 << i);
         if (c * c <= v) r = c;
      end
      return r;
   endfunction

   // divide by a small term index, each arm by a fixed divisor
   function automatic logic [63:0] div_small(input logic [63:0] x, input logic [4:0] n);
      logic [63:0] q;
      unique case (n)
         5'd1:  q = x / 1;
         5'd2:  q = x / 2;
         5'd3:  q = x / 3;
         5'd4:  q = x / 4;
         5'd5:  q = x / 5;
         5'd6:  q = x / 6;
         5'd7:  q = x / 7;
         5'd8:  q = x / 8;
         5'd9:  q = x / 9;
         5'd10: q = x / 10;
         5'd11: q = x / 11;
         5'd12: q = x / 12;
         5'd13: q = x / 13;
         5'd14: q = x / 14;
         5'd15: q = x / 15;
         5'd16: q = x / 16;
         5'd17: q = x / 17;
         5'd18: q = x / 18;
         5'd19: q = x / 19;
         5'd20: q = x / 20;
         5'd21: q = x / 21;
         5'd22: q = x / 22;
         5'd23: q = x / 23;
         5'd24: q = x / 24;
         default: q = x;
      endcase
      return q;
   endfunction

   // 255 * max(2 - exp(sqrt(e2)), 0), e2 in Q.32
   function automatic logic [WEIGHT_BITS-1:0] weight_of(input logic [63:0] e2);
      logic [63:0] d;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] two;
      logic [63:0] w;
      d    = isqrt(e2);
      term = 64'd1 << 32;
      sum  = term;
      two  = 64'd1 << 33;
      for (int n = 1; n <= EXP_TERMS; n++) begin
         term = div_small((term * d) >> 16, 5'(n));
         sum  = sum + term;
      end
      if (sum >= two) return '0;
      w = (64'd255 * (two - sum)) >> 32;
      return (w > 64'd255) ? WEIGHT_MAX : w[WEIGHT_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

/* rtl/bpas_lerp_cell.sv */
// One linear interpolation cell: r = a + floor(t * (b - a) / 2^T), three stages.
`default_nettype none
module bpas_lerp_cell #(
   parameter int T_FRAC_BITS = bpas_pkg::T_FRAC_BITS_DEF,
   parameter int VAL_BITS    = bpas_pkg::COORD_BITS_DEF + bpas_pkg::PFRAC
) (
   input  wire logic                 clock,
   input  wire logic [T_FRAC_BITS:0] in_t,
   input  wire logic [VAL_BITS-1:0]  in_a,
   input  wire logic [VAL_BITS-1:0]  in_b,
   output logic      [VAL_BITS-1:0]  out_r
);

   localparam int PW = T_FRAC_BITS + VAL_BITS + 3;

   logic signed [VAL_BITS:0]   diff_ff;
   logic        [VAL_BITS-1:0] a1_ff;
   logic        [T_FRAC_BITS:0] t1_ff;
   logic signed [PW-1:0]       prod_ff;
   logic        [VAL_BITS-1:0] a2_ff;
   logic        [VAL_BITS-1:0] r_ff;

   logic signed [PW-1:0]       t_ext;
   logic signed [PW-1:0]       diff_ext;
   logic signed [PW-1:0]       shr;
   logic signed [VAL_BITS+1:0] sum_in;

   always_ff @(posedge clock) begin
      diff_ff <= $signed({1'b0, in_b}) - $signed({1'b0, in_a});
      a1_ff   <= in_a;
      t1_ff   <= in_t;
   end

   assign t_ext    = PW'($signed({1'b0, t1_ff}));
   assign diff_ext = PW'(diff_ff);

   always_ff @(posedge clock) begin
      prod_ff <= t_ext * diff_ext;
      a2_ff   <= a1_ff;
   end

   assign shr    = prod_ff >>> T_FRAC_BITS;
   assign sum_in = $signed({2'b00, a2_ff}) + $signed(shr[VAL_BITS+1:0]);

   always_ff @(posedge clock) begin
      r_ff <= sum_in[VAL_BITS-1:0];
   end

   assign out_r = r_ff;

endmodule
`default_nettype wire

/* rtl/bpas_splat.sv */
// Splat stage: fractions, squared distances, weight table lookup, result register.
`default_nettype none
module bpas_splat #(
   parameter int COORD_BITS       = bpas_pkg::COORD_BITS_DEF,
   parameter int WEIGHT_ROM_DEPTH = bpas_pkg::WEIGHT_ROM_DEPTH_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   in_valid,
   input  wire logic [COORD_BITS+bpas_pkg::PFRAC-1:0]  in_px,
   input  wire logic [COORD_BITS+bpas_pkg::PFRAC-1:0]  in_py,
   output logic                                        out_valid,
   output logic [COORD_BITS-1:0]                       out_pixel_x,
   output logic [COORD_BITS-1:0]                       out_pixel_y,
   output logic [bpas_pkg::PFRAC-1:0]                  out_frac_x,
   output logic [bpas_pkg::PFRAC-1:0]                  out_frac_y,
   output logic [bpas_pkg::WEIGHT_BITS-1:0]            out_weight_here,
   output logic [bpas_pkg::WEIGHT_BITS-1:0]            out_weight_right,
   output logic [bpas_pkg::WEIGHT_BITS-1:0]            out_weight_below,
   output logic [bpas_pkg::WEIGHT_BITS-1:0]            out_weight_diag
);

   localparam int FB  = bpas_pkg::PFRAC;
   localparam int DB  = bpas_pkg::D2_BITS;
   localparam int WB  = bpas_pkg::WEIGHT_BITS;
   localparam int IW  = $clog2(WEIGHT_ROM_DEPTH);
   localparam int SW  = DB + IW + 1;
   localparam int HW  = SW - bpas_pkg::D2_SHIFT;
   localparam logic [HW-1:0] LAST_IDX = HW'(WEIGHT_ROM_DEPTH - 1);

   logic [WB-1:0] rom [WEIGHT_ROM_DEPTH];

   for (genvar k = 0; k < WEIGHT_ROM_DEPTH; k++) begin : g_rom
      localparam logic [63:0] E2 = (64'(k) << bpas_pkg::D2_SHIFT) / WEIGHT_ROM_DEPTH;
      localparam logic [WB-1:0] W = bpas_pkg::weight_of(E2);
      assign rom[k] = W;
   end

   // stage 1: squares; order fx, rx, fy, ry
   logic [FB-1:0]   fx;
   logic [FB-1:0]   fy;
   logic [FB:0]     rx;
   logic [FB:0]     ry;
   logic            v1_ff;
   logic [COORD_BITS-1:0] px1_ff;
   logic [COORD_BITS-1:0] py1_ff;
   logic [FB-1:0]   fx1_ff;
   logic [FB-1:0]   fy1_ff;
   logic [DB-1:0]   sq_ff [4];

   assign fx = in_px[FB-1:0];
   assign fy = in_py[FB-1:0];
   assign rx = (17'(1) << FB) - {1'b0, fx};
   assign ry = (17'(1) << FB) - {1'b0, fy};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      px1_ff   <= in_px[COORD_BITS+FB-1:FB];
      py1_ff   <= in_py[COORD_BITS+FB-1:FB];
      fx1_ff   <= fx;
      fy1_ff   <= fy;
      sq_ff[0] <= DB'(fx) * DB'(fx);
      sq_ff[1] <= DB'(rx) * DB'(rx);
      sq_ff[2] <= DB'(fy) * DB'(fy);
      sq_ff[3] <= DB'(ry) * DB'(ry);
   end

   // stage 2: table index per neighbor; here, right, below, diag
   logic [DB-1:0]   d2 [4];
   logic [SW-1:0]   scaled [4];
   logic [HW-1:0]   hi [4];
   logic [IW-1:0]   idx_in [4];
   logic            v2_ff;
   logic [COORD_BITS-1:0] px2_ff;
   logic [COORD_BITS-1:0] py2_ff;
   logic [FB-1:0]   fx2_ff;
   logic [FB-1:0]   fy2_ff;
   logic [IW-1:0]   idx_ff [4];

   assign d2[0] = sq_ff[0] + sq_ff[2];
   assign d2[1] = sq_ff[1] + sq_ff[2];
   assign d2[2] = sq_ff[0] + sq_ff[3];
   assign d2[3] = sq_ff[1] + sq_ff[3];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         scaled[i] = SW'(d2[i]) * SW'(WEIGHT_ROM_DEPTH);
         hi[i]     = HW'(scaled[i] >> bpas_pkg::D2_SHIFT);
         if (hi[i] > LAST_IDX) begin
            idx_in[i] = LAST_IDX[IW-1:0];
         end else begin
            idx_in[i] = hi[i][IW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      px2_ff <= px1_ff;
      py2_ff <= py1_ff;
      fx2_ff <= fx1_ff;
      fy2_ff <= fy1_ff;
      for (int i = 0; i < 4; i++) idx_ff[i] <= idx_in[i];
   end

   // stage 3: lookup into result register
   logic            v3_ff;
   logic [COORD_BITS-1:0] px3_ff;
   logic [COORD_BITS-1:0] py3_ff;
   logic [FB-1:0]   fx3_ff;
   logic [FB-1:0]   fy3_ff;
   logic [WB-1:0]   w_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      px3_ff <= px2_ff;
      py3_ff <= py2_ff;
      fx3_ff <= fx2_ff;
      fy3_ff <= fy2_ff;
      for (int i = 0; i < 4; i++) w_ff[i] <= rom[idx_ff[i]];
   end

   assign out_valid        = v3_ff;
   assign out_pixel_x      = px3_ff;
   assign out_pixel_y      = py3_ff;
   assign out_frac_x       = fx3_ff;
   assign out_frac_y       = fy3_ff;
   assign out_weight_here  = w_ff[0];
   assign out_weight_right = w_ff[1];
   assign out_weight_below = w_ff[2];
   assign out_weight_diag  = w_ff[3];

endmodule
`default_nettype wire

/* rtl/bezier_point_antialiased_splat.sv */
// Top level: cubic Bezier point via three rows of lerp cells, then a 2x2 weight splat.
//
//   channel   ports                          handshake
//   request   req_t_param                    start, busy
//   response  rsp_pixel_*, rsp_frac_*,       rsp_valid, one cycle, no backpressure
//             rsp_weight_*
//   config    csr_index, csr_data            csr_we
//
// A word is taken every clock; busy stays low.
// The path is one input register, three de Casteljau rows of
// three-stage lerp cells, and three splat stages ending in the table read.
// Synchronous reset clears the control points and all valid flags.
// The response side cannot stall; each word shows for exactly one cycle.
`default_nettype none
module bezier_point_antialiased_splat #(
   parameter int T_FRAC_BITS      = bpas_pkg::T_FRAC_BITS_DEF,
   parameter int COORD_BITS       = bpas_pkg::COORD_BITS_DEF,
   parameter int WEIGHT_ROM_DEPTH = bpas_pkg::WEIGHT_ROM_DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [T_FRAC_BITS:0]                req_t_param,
   output logic                                     rsp_valid,
   output logic [COORD_BITS-1:0]                    rsp_pixel_x,
   output logic [COORD_BITS-1:0]                    rsp_pixel_y,
   output logic [bpas_pkg::PFRAC-1:0]               rsp_frac_x,
   output logic [bpas_pkg::PFRAC-1:0]               rsp_frac_y,
   output logic [bpas_pkg::WEIGHT_BITS-1:0]         rsp_weight_here,
   output logic [bpas_pkg::WEIGHT_BITS-1:0]         rsp_weight_right,
   output logic [bpas_pkg::WEIGHT_BITS-1:0]         rsp_weight_below,
   output logic [bpas_pkg::WEIGHT_BITS-1:0]         rsp_weight_diag,
   input  wire logic                                csr_we,
   input  wire logic [bpas_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [COORD_BITS-1:0]               csr_data
);

   localparam int VB     = COORD_BITS + bpas_pkg::PFRAC;
   localparam int CL     = bpas_pkg::CELL_LAT;
   localparam int T_TAPS = (bpas_pkg::LEVELS - 1) * CL + 1;
   localparam int V_TAPS = bpas_pkg::LEVELS * CL + 1;
   localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

   assign busy = 1'b0;

   logic [COORD_BITS-1:0] p0_x_ff, p0_y_ff, p1_x_ff, p1_y_ff;
   logic [COORD_BITS-1:0] p2_x_ff, p2_y_ff, p3_x_ff, p3_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_x_ff <= '0;
         p0_y_ff <= '0;
         p1_x_ff <= '0;
         p1_y_ff <= '0;
         p2_x_ff <= '0;
         p2_y_ff <= '0;
         p3_x_ff <= '0;
         p3_y_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            bpas_pkg::REG_P0_X: p0_x_ff <= csr_data;
            bpas_pkg::REG_P0_Y: p0_y_ff <= csr_data;
            bpas_pkg::REG_P1_X: p1_x_ff <= csr_data;
            bpas_pkg::REG_P1_Y: p1_y_ff <= csr_data;
            bpas_pkg::REG_P2_X: p2_x_ff <= csr_data;
            bpas_pkg::REG_P2_Y: p2_y_ff <= csr_data;
            bpas_pkg::REG_P3_X: p3_x_ff <= csr_data;
            bpas_pkg::REG_P3_Y: p3_y_ff <= csr_data;
         endcase
      end
   end

   // t and valid travel beside the cell rows; row L reads tap (L-1)*CELL_LAT
   logic [T_FRAC_BITS:0] t_in;
   logic [T_FRAC_BITS:0] t_ff [T_TAPS];
   logic                 v_ff [V_TAPS];

   assign t_in = (req_t_param > T_ONE) ? T_ONE : req_t_param;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < V_TAPS; i++) v_ff[i] <= 1'b0;
      end else begin
         v_ff[0] <= start & ~busy;
         for (int i = 1; i < V_TAPS; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      t_ff[0] <= t_in;
      for (int i = 1; i < T_TAPS; i++) t_ff[i] <= t_ff[i-1];
   end

   logic [VB-1:0] x0 [4];
   logic [VB-1:0] y0 [4];
   logic [VB-1:0] x1 [3];
   logic [VB-1:0] y1 [3];
   logic [VB-1:0] x2 [2];
   logic [VB-1:0] y2 [2];
   logic [VB-1:0] x3;
   logic [VB-1:0] y3;

   assign x0[0] = {p0_x_ff, {bpas_pkg::PFRAC{1'b0}}};
   assign x0[1] = {p1_x_ff, {bpas_pkg::PFRAC{1'b0}}};
   assign x0[2] = {p2_x_ff, {bpas_pkg::PFRAC{1'b0}}};
   assign x0[3] = {p3_x_ff, {bpas_pkg::PFRAC{1'b0}}};
   assign y0[0] = {p0_y_ff, {bpas_pkg::PFRAC{1'b0}}};
   assign y0[1] = {p1_y_ff, {bpas_pkg::PFRAC{1'b0}}};
   assign y0[2] = {p2_y_ff, {bpas_pkg::PFRAC{1'b0}}};
   assign y0[3] = {p3_y_ff, {bpas_pkg::PFRAC{1'b0}}};

   for (genvar i = 0; i < 3; i++) begin : g_row1
      bpas_lerp_cell #(.T_FRAC_BITS(T_FRAC_BITS), .VAL_BITS(VB)) u_cx (
         .clock(clock), .in_t(t_ff[0]), .in_a(x0[i]), .in_b(x0[i+1]), .out_r(x1[i])
      );
      bpas_lerp_cell #(.T_FRAC_BITS(T_FRAC_BITS), .VAL_BITS(VB)) u_cy (
         .clock(clock), .in_t(t_ff[0]), .in_a(y0[i]), .in_b(y0[i+1]), .out_r(y1[i])
      );
   end

   for (genvar i = 0; i < 2; i++) begin : g_row2
      bpas_lerp_cell #(.T_FRAC_BITS(T_FRAC_BITS), .VAL_BITS(VB)) u_cx (
         .clock(clock), .in_t(t_ff[CL]), .in_a(x1[i]), .in_b(x1[i+1]), .out_r(x2[i])
      );
      bpas_lerp_cell #(.T_FRAC_BITS(T_FRAC_BITS), .VAL_BITS(VB)) u_cy (
         .clock(clock), .in_t(t_ff[CL]), .in_a(y1[i]), .in_b(y1[i+1]), .out_r(y2[i])
      );
   end

   bpas_lerp_cell #(.T_FRAC_BITS(T_FRAC_BITS), .VAL_BITS(VB)) u_row3_x (
      .clock(clock), .in_t(t_ff[2*CL]), .in_a(x2[0]), .in_b(x2[1]), .out_r(x3)
   );
   bpas_lerp_cell #(.T_FRAC_BITS(T_FRAC_BITS), .VAL_BITS(VB)) u_row3_y (
      .clock(clock), .in_t(t_ff[2*CL]), .in_a(y2[0]), .in_b(y2[1]), .out_r(y3)
   );

   bpas_splat #(
      .COORD_BITS      (COORD_BITS),
      .WEIGHT_ROM_DEPTH(WEIGHT_ROM_DEPTH)
   ) u_splat (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (v_ff[V_TAPS-1]),
      .in_px           (x3),
      .in_py           (y3),
      .out_valid       (rsp_valid),
      .out_pixel_x     (rsp_pixel_x),
      .out_pixel_y     (rsp_pixel_y),
      .out_frac_x      (rsp_frac_x),
      .out_frac_y      (rsp_frac_y),
      .out_weight_here (rsp_weight_here),
      .out_weight_right(rsp_weight_right),
      .out_weight_below(rsp_weight_below),
      .out_weight_diag (rsp_weight_diag)
   );

endmodule
`default_nettype wire

/* rtl/bpas_checker.sv */
// Port-level checks for the Bezier point splat block, bound to the top level.
`default_nettype none
module bpas_checker #(
   parameter int COORD_BITS = bpas_pkg::COORD_BITS_DEF
) (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               start,
   input wire logic                               busy,
   input wire logic                               rsp_valid,
   input wire logic [bpas_pkg::PFRAC-1:0]         rsp_frac_x,
   input wire logic [bpas_pkg::PFRAC-1:0]         rsp_frac_y,
   input wire logic [bpas_pkg::WEIGHT_BITS-1:0]   rsp_weight_here,
   input wire logic [bpas_pkg::WEIGHT_BITS-1:0]   rsp_weight_right,
   input wire logic [bpas_pkg::WEIGHT_BITS-1:0]   rsp_weight_below,
   input wire logic [bpas_pkg::WEIGHT_BITS-1:0]   rsp_weight_diag,
   input wire logic [COORD_BITS-1:0]              rsp_pixel_x
);

   a_word_comes_out: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##(bpas_pkg::LATENCY) rsp_valid)
      else $error("accepted word produced no response");

   a_no_spurious_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, bpas_pkg::LATENCY))
      else $error("response without a matching request");

   a_on_pixel_weights: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frac_x == '0 && rsp_frac_y == '0 |->
         rsp_weight_here == bpas_pkg::WEIGHT_MAX && rsp_weight_right == '0 &&
         rsp_weight_below == '0 && rsp_weight_diag == '0)
      else $error("weights wrong for a point on a pixel corner, pixel %0d", rsp_pixel_x);

endmodule

bind bezier_point_antialiased_splat bpas_checker #(.COORD_BITS(COORD_BITS)) u_bpas_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_frac_x      (rsp_frac_x),
   .rsp_frac_y      (rsp_frac_y),
   .rsp_weight_here (rsp_weight_here),
   .rsp_weight_right(rsp_weight_right),
   .rsp_weight_below(rsp_weight_below),
   .rsp_weight_diag (rsp_weight_diag),
   .rsp_pixel_x     (rsp_pixel_x)
);
`default_nettype wire

/* test/bezier_point_antialiased_splat_checker.sv */
// Checker for the Bezier point splat block: predicts each word and compares results.
`default_nettype none
module bezier_point_antialiased_splat_checker
   import bpas_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic                        busy,
   input  wire logic [T_FRAC_BITS_DEF:0]    req_t_param,
   input  wire logic                        rsp_valid,
   input  wire logic [COORD_BITS_DEF-1:0]   rsp_pixel_x,
   input  wire logic [COORD_BITS_DEF-1:0]   rsp_pixel_y,
   input  wire logic [PFRAC-1:0]            rsp_frac_x,
   input  wire logic [PFRAC-1:0]            rsp_frac_y,
   input  wire logic [WEIGHT_BITS-1:0]      rsp_weight_here,
   input  wire logic [WEIGHT_BITS-1:0]      rsp_weight_right,
   input  wire logic [WEIGHT_BITS-1:0]      rsp_weight_below,
   input  wire logic [WEIGHT_BITS-1:0]      rsp_weight_diag,
   input  wire logic                        csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [COORD_BITS_DEF-1:0]   csr_data,
   output int                               outstanding,
   output int                               failures
);

   typedef logic [63:0] u64_type;

   typedef struct packed {
      logic [COORD_BITS_DEF-1:0] pixel_x;
      logic [COORD_BITS_DEF-1:0] pixel_y;
      logic [PFRAC-1:0]          frac_x;
      logic [PFRAC-1:0]          frac_y;
      logic [WEIGHT_BITS-1:0]    w_here;
      logic [WEIGHT_BITS-1:0]    w_right;
      logic [WEIGHT_BITS-1:0]    w_below;
      logic [WEIGHT_BITS-1:0]    w_diag;
   } splat_word_type;

   localparam u64_type T_ONE = u64_type'(1) << T_FRAC_BITS_DEF;

   logic [WEIGHT_BITS-1:0]    falloff_rom [WEIGHT_ROM_DEPTH_DEF];
   logic [COORD_BITS_DEF-1:0] ctrl_x [4];
   logic [COORD_BITS_DEF-1:0] ctrl_y [4];
   splat_word_type            expected_q [$];
   int                        fail_count;

   function automatic u64_type root_floor(input u64_type v);
      u64_type r;
      u64_type c;
      r = '0;
      for (int b = 20; b >= 0; b--) begin
         c = r | (u64_type'(1) << b);
         if (c * c <= v) r = c;
      end
      return r;
   endfunction

   // 255 * max(2 - exp(sqrt(e2)), 0) with a truncated Taylor series
   function automatic logic [WEIGHT_BITS-1:0] falloff_weight(input u64_type e2);
      u64_type root_val;
      u64_type term;
      u64_type sum;
      u64_type two;
      u64_type w;
      root_val = root_floor(e2);
      term = u64_type'(1) << 32;
      sum  = term;
      two  = u64_type'(1) << 33;
      for (int n = 1; n <= EXP_TERMS; n++) begin
         term = (term * root_val) / (u64_type'(n) << 16);
         sum  = sum + term;
      end
      if (sum >= two) return '0;
      w = (u64_type'(255) * (two - sum)) >> 32;
      return (w > 255) ? 8'd255 : w[WEIGHT_BITS-1:0];
   endfunction

   function automatic u64_type blend(input u64_type a, input u64_type b, input u64_type t);
      return ((T_ONE - t) * a + t * b) >> T_FRAC_BITS_DEF;
   endfunction

   function automatic u64_type bezier_coord(input u64_type c0, input u64_type c1,
                                            input u64_type c2, input u64_type c3,
                                            input u64_type t);
      u64_type ab;
      u64_type bc;
      u64_type cd;
      ab = blend(c0 << PFRAC, c1 << PFRAC, t);
      bc = blend(c1 << PFRAC, c2 << PFRAC, t);
      cd = blend(c2 << PFRAC, c3 << PFRAC, t);
      return blend(blend(ab, bc, t), blend(bc, cd, t), t);
   endfunction

   function automatic logic [WEIGHT_BITS-1:0] splat_weight(input u64_type dx,
                                                           input u64_type dy);
      u64_type idx;
      idx = ((dx * dx + dy * dy) * WEIGHT_ROM_DEPTH_DEF) >> D2_SHIFT;
      if (idx >= WEIGHT_ROM_DEPTH_DEF) idx = WEIGHT_ROM_DEPTH_DEF - 1;
      return falloff_rom[idx];
   endfunction

   function automatic splat_word_type predict_splat(input logic [T_FRAC_BITS_DEF:0] t_raw);
      u64_type t;
      u64_type px;
      u64_type py;
      u64_type fx;
      u64_type fy;
      u64_type rx;
      u64_type ry;
      splat_word_type w;
      t = u64_type'(t_raw);
      if (t > T_ONE) t = T_ONE;
      px = bezier_coord(ctrl_x[0], ctrl_x[1], ctrl_x[2], ctrl_x[3], t);
      py = bezier_coord(ctrl_y[0], ctrl_y[1], ctrl_y[2], ctrl_y[3], t);
      fx = px[PFRAC-1:0];
      fy = py[PFRAC-1:0];
      rx = (u64_type'(1) << PFRAC) - fx;
      ry = (u64_type'(1) << PFRAC) - fy;
      w.pixel_x = px[PFRAC +: COORD_BITS_DEF];
      w.pixel_y = py[PFRAC +: COORD_BITS_DEF];
      w.frac_x  = fx[PFRAC-1:0];
      w.frac_y  = fy[PFRAC-1:0];
      w.w_here  = splat_weight(fx, fy);
      w.w_right = splat_weight(rx, fy);
      w.w_below = splat_weight(fx, ry);
      w.w_diag  = splat_weight(rx, ry);
      return w;
   endfunction

   task automatic check_field(input string name, input u64_type want, input u64_type got);
      if (got !== want) begin
         $error("%s expected %0d actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      for (int k = 0; k < WEIGHT_ROM_DEPTH_DEF; k++)
         falloff_rom[k] = falloff_weight((u64_type'(k) << D2_SHIFT) / WEIGHT_ROM_DEPTH_DEF);
   end

   always @(posedge clock) begin
      splat_word_type want;
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            ctrl_x[i] = '0;
            ctrl_y[i] = '0;
         end
         expected_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_P0_X: ctrl_x[0] = csr_data;
               REG_P0_Y: ctrl_y[0] = csr_data;
               REG_P1_X: ctrl_x[1] = csr_data;
               REG_P1_Y: ctrl_y[1] = csr_data;
               REG_P2_X: ctrl_x[2] = csr_data;
               REG_P2_Y: ctrl_y[2] = csr_data;
               REG_P3_X: ctrl_x[3] = csr_data;
               REG_P3_Y: ctrl_y[3] = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid === 1'b1) begin
            if (expected_q.size() == 0) begin
               $error("result word with no expectation pending");
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               check_field("pixel_x", want.pixel_x, rsp_pixel_x);
               check_field("pixel_y", want.pixel_y, rsp_pixel_y);
               check_field("frac_x", want.frac_x, rsp_frac_x);
               check_field("frac_y", want.frac_y, rsp_frac_y);
               check_field("weight_here", want.w_here, rsp_weight_here);
               check_field("weight_right", want.w_right, rsp_weight_right);
               check_field("weight_below", want.w_below, rsp_weight_below);
               check_field("weight_diag", want.w_diag, rsp_weight_diag);
            end
         end else if (rsp_valid !== 1'b0) begin
            $error("rsp_valid expected 0 or 1 actual %b", rsp_valid);
            fail_count++;
         end
         if (start && !busy)
            expected_q.insert(expected_q.size(), predict_splat(req_t_param));
      end
      outstanding <= expected_q.size();
      failures    <= fail_count;
   end

endmodule
`default_nettype wire

/* test/bezier_point_antialiased_splat_tb.sv */
// Testbench top for the Bezier point splat block: clock, reset, stimulus and verdict.
`default_nettype none
module bezier_point_antialiased_splat_tb;
   import bpas_pkg::*;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic [T_FRAC_BITS_DEF:0]    req_t_param = '0;
   logic                        csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0]   csr_index = REG_P0_X;
   logic [COORD_BITS_DEF-1:0]   csr_data = '0;
   wire logic                   busy;
   wire logic                   rsp_valid;
   wire logic [COORD_BITS_DEF-1:0] rsp_pixel_x;
   wire logic [COORD_BITS_DEF-1:0] rsp_pixel_y;
   wire logic [PFRAC-1:0]       rsp_frac_x;
   wire logic [PFRAC-1:0]       rsp_frac_y;
   wire logic [WEIGHT_BITS-1:0] rsp_weight_here;
   wire logic [WEIGHT_BITS-1:0] rsp_weight_right;
   wire logic [WEIGHT_BITS-1:0] rsp_weight_below;
   wire logic [WEIGHT_BITS-1:0] rsp_weight_diag;
   int                          outstanding;
   int                          failures;

   localparam int T_MAX      = (1 << (T_FRAC_BITS_DEF + 1)) - 1;
   localparam int T_UNIT     = 1 << T_FRAC_BITS_DEF;
   localparam int COORD_MAX  = (1 << COORD_BITS_DEF) - 1;
   localparam int RAND_SETS  = 6;
   localparam int SET_WORDS  = 313;

   bezier_point_antialiased_splat u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_t_param      (req_t_param),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_frac_x       (rsp_frac_x),
      .rsp_frac_y       (rsp_frac_y),
      .rsp_weight_here  (rsp_weight_here),
      .rsp_weight_right (rsp_weight_right),
      .rsp_weight_below (rsp_weight_below),
      .rsp_weight_diag  (rsp_weight_diag),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   bezier_point_antialiased_splat_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_t_param      (req_t_param),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_frac_x       (rsp_frac_x),
      .rsp_frac_y       (rsp_frac_y),
      .rsp_weight_here  (rsp_weight_here),
      .rsp_weight_right (rsp_weight_right),
      .rsp_weight_below (rsp_weight_below),
      .rsp_weight_diag  (rsp_weight_diag),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .outstanding      (outstanding),
      .failures         (failures)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_word(input int t);
      start       <= 1'b1;
      req_t_param <= t[T_FRAC_BITS_DEF:0];
      do @(posedge clock); while (busy);
   endtask

   // stop sending and wait until every predicted word has come back
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic csr_put(input logic [CSR_INDEX_BITS-1:0] idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[COORD_BITS_DEF-1:0];
      @(posedge clock);
   endtask

   task automatic load_curve(input int x0, input int y0, input int x1, input int y1,
                             input int x2, input int y2, input int x3, input int y3);
      csr_put(REG_P0_X, x0);
      csr_put(REG_P0_Y, y0);
      csr_put(REG_P1_X, x1);
      csr_put(REG_P1_Y, y1);
      csr_put(REG_P2_X, x2);
      csr_put(REG_P2_Y, y2);
      csr_put(REG_P3_X, x3);
      csr_put(REG_P3_Y, y3);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int pick_coord();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return COORD_MAX;
         default: return $urandom_range(0, COORD_MAX);
      endcase
   endfunction

   function automatic int pick_t();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, T_MAX);
         1: begin
            case ($urandom_range(0, 5))
               0: return 0;
               1: return 1;
               2: return T_UNIT - 1;
               3: return T_UNIT;
               4: return T_UNIT + 1;
               default: return T_MAX;
            endcase
         end
         default: return $urandom_range(0, T_UNIT);
      endcase
   endfunction

   task automatic send_directed(input int t_list[$]);
      foreach (t_list[i]) send_word(t_list[i]);
      drain();
   endtask

   // random words in bursts; one mid-set pause waits for all results
   task automatic send_random_set(input int words);
      int burst_left;
      int pause_at;
      burst_left = 0;
      pause_at   = $urandom_range(words / 4, 3 * words / 4);
      for (int i = 0; i < words; i++) begin
         if (i == pause_at) begin
            drain();
            burst_left = 0;
         end
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (i > 0 && $urandom_range(0, 3) != 0) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
         send_word(pick_t());
         burst_left--;
      end
      drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset control points: every t lands on the origin
      send_directed('{0, T_UNIT, T_MAX});

      load_curve(0, 0, COORD_MAX, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX);
      send_directed('{0, 1, T_UNIT / 2, T_UNIT - 1, T_UNIT, T_UNIT + 1,
                      3 * T_UNIT / 2, T_MAX, 21845, 43690});

      load_curve(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                 COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      send_directed('{0, T_UNIT / 2, T_UNIT, T_MAX});

      load_curve(COORD_MAX, COORD_MAX, 0, COORD_MAX, COORD_MAX, 0, 0, 0);
      send_directed('{0, T_UNIT / 4, 3 * T_UNIT / 4, T_UNIT, 70000});

      for (int s = 0; s < RAND_SETS; s++) begin
         load_curve(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                    pick_coord(), pick_coord(), pick_coord(), pick_coord());
         send_random_set(SET_WORDS);
      end

      repeat (LATENCY + 4) @(posedge clock);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
`default_nettype wire

/* files.f */
rtl/bpas_pkg.sv
rtl/bpas_lerp_cell.sv
rtl/bpas_splat.sv
rtl/bezier_point_antialiased_splat.sv
rtl/bpas_checker.sv
test/bezier_point_antialiased_splat_checker.sv
test/bezier_point_antialiased_splat_tb.sv
